// ===== rtl/cssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cssp_pkg;

    typedef enum logic [3:0] {
        M_LINE  = 4'd0,
        M_KEY   = 4'd1,
        M_REST  = 4'd2,
        M_QTRK  = 4'd3,
        M_QOTH  = 4'd4,
        M_BTRK  = 4'd5,
        M_BOTH  = 4'd6,
        M_IWAIT = 4'd7,
        M_IDIG  = 4'd8
    } cssp_mode_t;

    localparam logic [2:0] KIND_TRACK     = 3'd0;
    localparam logic [2:0] KIND_TITLE     = 3'd1;
    localparam logic [2:0] KIND_TITLE_END = 3'd2;
    localparam logic [2:0] KIND_POSITION  = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;
    localparam logic [2:0] KIND_DONE      = 3'd5;

    localparam logic [2:0] ERR_TOO_MANY    = 3'd0;
    localparam logic [2:0] ERR_NO_TRACK    = 3'd1;
    localparam logic [2:0] ERR_BAD_INDEX   = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN_KW  = 3'd3;
    localparam logic [2:0] ERR_QUOTE       = 3'd4;
    localparam logic [2:0] ERR_UNTERM      = 3'd5;

    localparam logic [2:0] KW_REM   = 3'd0;
    localparam logic [2:0] KW_PERF  = 3'd1;
    localparam logic [2:0] KW_TITLE = 3'd2;
    localparam logic [2:0] KW_TRACK = 3'd3;
    localparam logic [2:0] KW_INDEX = 3'd4;
    localparam logic [2:0] KW_FILE  = 3'd5;
    localparam logic [2:0] KW_NONE  = 3'd7;

    localparam logic [6:0]  TRACK_CAP = 7'd100;
    localparam logic [21:0] POS_MAX   = 22'h3FFFFF;
    localparam int          FIFO_DEPTH = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [6:0]  track_index;
        logic [21:0] event_value;
        logic [2:0]  err_code;
        logic        last_result;
    } cssp_result_t;

    typedef struct packed {
        logic [1:0]   count;
        cssp_result_t r1;
        cssp_result_t r0;
    } cssp_push_t;

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        case (k)
            KW_REM:   kw_len = 4'd3;
            KW_PERF:  kw_len = 4'd9;
            KW_TITLE: kw_len = 4'd5;
            KW_TRACK: kw_len = 4'd5;
            KW_INDEX: kw_len = 4'd5;
            KW_FILE:  kw_len = 4'd4;
            default:  kw_len = 4'd0;
        endcase
    endfunction

    // character at position p of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [4:0] p);
        logic [71:0] s;
        logic [3:0]  l;
        logic [6:0]  sh;
        begin
            case (k)
                KW_REM:   s = 72'("REM");
                KW_PERF:  s = 72'("PERFORMER");
                KW_TITLE: s = 72'("TITLE");
                KW_TRACK: s = 72'("TRACK");
                KW_INDEX: s = 72'("INDEX");
                KW_FILE:  s = 72'("FILE");
                default:  s = '0;
            endcase
            l = kw_len(k);
            if ({1'b0, p} < {2'b0, l})
            begin
                sh = 7'({3'b0, l} - 7'd1 - {2'b0, p}) << 3;
                kw_char = s[sh +: 8];
            end
            else
            begin
                kw_char = 8'd0;
            end
        end
    endfunction

    // t below 750: quotient by 75 as a compare chain
    function automatic logic [3:0] div75_small(input logic [9:0] t);
        logic [3:0] q;
        begin
            q = 4'd0;
            for (int i = 1; i <= 9; i++)
            begin
                if (t >= 10'(75 * i))
                    q = 4'(i);
            end
            div75_small = q;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cssp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cssp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/cssp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cssp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [6:0]  track_index;
    logic [21:0] event_value;
    logic [2:0]  err_code;
    logic        last_result;

    modport source (output valid, output event_kind, output track_index,
                    output event_value, output err_code, output last_result, input ready);
    modport sink (input valid, input event_kind, input track_index,
                  input event_value, input err_code, input last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/cssp_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cssp_out_fifo
    import cssp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  cssp_push_t  push,
    output logic [2:0]  count,
    cssp_out_if.source  out_ch
);

    cssp_result_t mem_reg [FIFO_DEPTH];
    logic [1:0]   rd_ptr_reg, rd_ptr_next;
    logic [1:0]   wr_ptr_reg, wr_ptr_next;
    logic [2:0]   count_reg, count_next;
    logic         pop;
    cssp_result_t head;

    assign pop   = out_ch.valid && out_ch.ready;
    assign count = count_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        wr_ptr_next = wr_ptr_reg + push.count;
        count_next  = count_reg + 3'(push.count) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
    end

    assign head = mem_reg[rd_ptr_reg];

    assign out_ch.valid       = (count_reg != 3'd0);
    assign out_ch.event_kind  = head.event_kind;
    assign out_ch.track_index = head.track_index;
    assign out_ch.event_value = head.event_value;
    assign out_ch.err_code    = head.err_code;
    assign out_ch.last_result = head.last_result;

endmodule

`default_nettype wire

// ===== rtl/cue_sheet_stream_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Results: a byte's results are written into the output queue at the edge that takes the byte,
//   and the queue head is driven onto the output channel straight from the queue registers.
// Throughput: one byte per cycle; a byte is taken while the four-entry result queue
//   has room for two results, so a slow sink stalls input once the queue holds three.
// Reset (rst_n, async, low): parser to line start, no tracks, queue empty, max_tracks 100.

module cue_sheet_stream_parser_top
    import cssp_pkg::*;
#(
    parameter int TITLE_MAX    = 256,
    parameter int NUMBER_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    cssp_in_if.sink          in_ch,
    cssp_out_if.source       out_ch
);

    localparam int N     = NUMBER_WIDTH;
    localparam int TL_W  = $clog2(TITLE_MAX + 1);
    localparam int SUM_W = (N + 7 > 22) ? N + 7 : 23;
    localparam logic [N-1:0] NMAX   = {N{1'b1}};
    localparam logic [63:0]  NMAX_W = (64'd1 << N) - 64'd1;
    localparam logic [N-1:0] NMAX_Q = N'(NMAX_W / 64'd75);
    localparam logic [6:0]   NMAX_R = 7'(NMAX_W % 64'd75);

    // configuration
    logic [6:0] max_tracks_reg;
    logic [6:0] limit;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {25'd0, max_tracks_reg};
    assign limit  = (max_tracks_reg > TRACK_CAP) ? TRACK_CAP : max_tracks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_tracks_reg <= TRACK_CAP;
        else if (psel && penable && pwrite && !paddr[2])
            max_tracks_reg <= pwdata[6:0];
    end

    // parser state
    cssp_mode_t     mode_reg, mode_next;
    logic [5:0]     match_reg, match_next;
    logic [4:0]     klen_reg, klen_next;
    logic [6:0]     tcount_reg, tcount_next;
    logic           topen_reg, topen_next;
    logic [N-1:0]   field_reg [4];
    logic [N-1:0]   field_next [4];
    logic [N-1:0]   quot_reg, quot_next;    // running frames / 75
    logic [6:0]     rem_reg, rem_next;      // running frames % 75
    logic [1:0]     fcount_reg, fcount_next;
    logic [TL_W-1:0] tlen_reg, tlen_next;
    logic           halted_reg, halted_next;

    logic [2:0]     fifo_count;
    cssp_push_t     push;
    logic           accept;

    // room for the worst case of two results
    assign in_ch.ready = (fifo_count <= 3'd2);
    assign accept      = in_ch.valid && in_ch.ready;

    function automatic cssp_result_t mk(input logic [2:0] kind, input logic [21:0] value,
                                        input logic [2:0] err, input logic open,
                                        input logic [6:0] cnt);
        cssp_result_t r;
        begin
            r.event_kind  = kind;
            r.track_index = open ? (cnt - 7'd1) : 7'd0;
            r.event_value = value;
            r.err_code    = err;
            r.last_result = 1'b0;
            mk = r;
        end
    endfunction

    function automatic logic [5:0] feed(input logic [5:0] m, input logic [4:0] l,
                                        input logic [7:0] b);
        logic [5:0] r;
        begin
            r = m;
            for (int k = 0; k < 6; k++)
            begin
                if ({1'b0, l} >= {2'b0, kw_len(3'(k))} || kw_char(3'(k), l) != b)
                    r[k] = 1'b0;
            end
            feed = r;
        end
    endfunction

    function automatic logic [21:0] position(input logic [N-1:0] q, input logic [N-1:0] s,
                                             input logic [N-1:0] m);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(q) + SUM_W'(s) + SUM_W'(m) * SUM_W'(60);
            position = (sum > SUM_W'(POS_MAX)) ? POS_MAX : sum[21:0];
        end
    endfunction

    always_comb
    begin
        logic [7:0]   b;
        logic         eot, blank, crlf, digit, do_res;
        logic [3:0]   d;
        logic [1:0]   n;
        logic [2:0]   found;
        logic [N+3:0] v;
        logic [9:0]   t;
        logic [3:0]   tq;
        cssp_result_t res [2];

        b     = in_ch.in_byte;
        eot   = in_ch.end_of_text;
        blank = (b == CH_SPACE) || (b == CH_TAB);
        crlf  = (b == CH_CR) || (b == CH_LF);
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        d     = 4'(b - CH_ZERO);
        n      = 2'd0;
        do_res = 1'b0;
        found  = KW_NONE;
        v      = '0;
        t      = '0;
        tq     = '0;
        res[0] = '0;
        res[1] = '0;

        mode_next   = mode_reg;
        match_next  = match_reg;
        klen_next   = klen_reg;
        tcount_next = tcount_reg;
        topen_next  = topen_reg;
        for (int i = 0; i < 4; i++)
            field_next[i] = field_reg[i];
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        fcount_next = fcount_reg;
        tlen_next   = tlen_reg;
        halted_next = halted_reg;

        if (accept && !halted_reg)
        begin
            // byte itself
            case (mode_reg)
                M_LINE:
                begin
                    if (!(blank || crlf))
                    begin
                        match_next = feed(6'h3F, 5'd0, b);
                        klen_next  = 5'd1;
                        mode_next  = M_KEY;
                    end
                end
                M_KEY:
                begin
                    if (blank)
                        do_res = 1'b1;
                    else if (crlf)
                    begin
                        res[n[0]] = mk(KIND_ERROR, '0, ERR_UNKNOWN_KW, topen_next, tcount_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        match_next = feed(match_reg, klen_reg, b);
                        if (klen_reg != 5'd31)
                            klen_next = klen_reg + 5'd1;
                    end
                end
                M_REST:
                begin
                    if (b == CH_LF)
                        mode_next = M_LINE;
                end
                M_QTRK, M_QOTH:
                begin
                    if (!blank)
                    begin
                        if (b != CH_QUOTE)
                        begin
                            res[n[0]] = mk(KIND_ERROR, '0, ERR_QUOTE, topen_next, tcount_next);
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            tlen_next = '0;
                            mode_next = (mode_reg == M_QTRK) ? M_BTRK : M_BOTH;
                        end
                    end
                end
                M_BTRK:
                begin
                    if (b == CH_QUOTE)
                    begin
                        res[n[0]] = mk(KIND_TITLE_END, '0, 3'd0, topen_next, tcount_next);
                        n = n + 2'd1;
                        mode_next = M_REST;
                    end
                    else if (32'(tlen_reg) < TITLE_MAX)
                    begin
                        res[n[0]] = mk(KIND_TITLE, 22'(b), 3'd0, topen_next, tcount_next);
                        n = n + 2'd1;
                        tlen_next = tlen_reg + TL_W'(1);
                    end
                end
                M_BOTH:
                begin
                    if (b == CH_QUOTE)
                        mode_next = M_REST;
                end
                M_IWAIT:
                begin
                    if (digit)
                    begin
                        field_next[fcount_reg] = N'(d);
                        quot_next = '0;
                        rem_next  = 7'(d);
                        mode_next = M_IDIG;
                    end
                    else if (!blank)
                    begin
                        res[n[0]] = mk(KIND_ERROR, '0, ERR_BAD_INDEX, topen_next, tcount_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                end
                M_IDIG:
                begin
                    if (digit)
                    begin
                        v  = (N+4)'(field_reg[fcount_reg]) * (N+4)'(10) + (N+4)'(d);
                        t  = 10'(rem_reg) * 10'd10 + 10'(d);
                        tq = div75_small(t);
                        if (v > (N+4)'(NMAX))
                        begin
                            field_next[fcount_reg] = NMAX;
                            quot_next = NMAX_Q;
                            rem_next  = NMAX_R;
                        end
                        else
                        begin
                            field_next[fcount_reg] = v[N-1:0];
                            quot_next = N'((N+4)'(quot_reg) * (N+4)'(10) + (N+4)'(tq));
                            rem_next  = 7'(t - 10'(tq) * 10'd75);
                        end
                    end
                    else if (fcount_reg == 2'd0 && blank)
                    begin
                        fcount_next = 2'd1;
                        mode_next   = M_IWAIT;
                    end
                    else if ((fcount_reg == 2'd1 || fcount_reg == 2'd2) && b == CH_COLON)
                    begin
                        fcount_next = fcount_reg + 2'd1;
                        mode_next   = M_IWAIT;
                    end
                    else if (fcount_reg == 2'd3)
                    begin
                        if (field_reg[0] == N'(1))
                        begin
                            res[n[0]] = mk(KIND_POSITION,
                                           position(quot_reg, field_reg[2], field_reg[1]),
                                           3'd0, topen_next, tcount_next);
                            n = n + 2'd1;
                        end
                        mode_next = (b == CH_LF) ? M_LINE : M_REST;
                    end
                    else
                    begin
                        res[n[0]] = mk(KIND_ERROR, '0, ERR_BAD_INDEX, topen_next, tcount_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                end
                default:
                    mode_next = M_LINE;
            endcase

            // keyword resolution, on a blank or at end of text
            if (do_res || (eot && !halted_next && mode_next == M_KEY))
            begin
                for (int k = 0; k < 6; k++)
                begin
                    if (match_next[k] && {1'b0, kw_len(3'(k))} == klen_next)
                        found = 3'(k);
                end
                case (found)
                    KW_REM, KW_FILE:
                        mode_next = M_REST;
                    KW_PERF:
                        mode_next = M_QOTH;
                    KW_TITLE:
                        mode_next = topen_next ? M_QTRK : M_QOTH;
                    KW_TRACK:
                    begin
                        if (tcount_next >= limit)
                        begin
                            res[n[0]] = mk(KIND_ERROR, '0, ERR_TOO_MANY, topen_next,
                                           tcount_next);
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            tcount_next = tcount_next + 7'd1;
                            topen_next  = 1'b1;
                            tlen_next   = '0;
                            res[n[0]] = mk(KIND_TRACK, '0, 3'd0, topen_next, tcount_next);
                            n = n + 2'd1;
                            mode_next = M_REST;
                        end
                    end
                    KW_INDEX:
                    begin
                        if (!topen_next)
                        begin
                            res[n[0]] = mk(KIND_ERROR, '0, ERR_NO_TRACK, topen_next,
                                           tcount_next);
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                                field_next[i] = '0;
                            fcount_next = 2'd0;
                            mode_next   = M_IWAIT;
                        end
                    end
                    default:
                    begin
                        res[n[0]] = mk(KIND_ERROR, '0, ERR_UNKNOWN_KW, topen_next, tcount_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                endcase
            end

            // end of text: close out whatever is pending
            if (eot && !halted_next)
            begin
                case (mode_next)
                    M_QTRK, M_QOTH:
                    begin
                        res[n[0]] = mk(KIND_ERROR, '0, ERR_QUOTE, topen_next, tcount_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                    M_BTRK, M_BOTH:
                    begin
                        res[n[0]] = mk(KIND_ERROR, '0, ERR_UNTERM, topen_next, tcount_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                    M_IWAIT:
                    begin
                        res[n[0]] = mk(KIND_ERROR, '0, ERR_BAD_INDEX, topen_next, tcount_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                    default:
                    begin
                        if (mode_next == M_IDIG && fcount_next != 2'd3)
                        begin
                            res[n[0]] = mk(KIND_ERROR, '0, ERR_BAD_INDEX, topen_next,
                                           tcount_next);
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            if (mode_next == M_IDIG && field_next[0] == N'(1))
                            begin
                                res[n[0]] = mk(KIND_POSITION,
                                               position(quot_next, field_next[2], field_next[1]),
                                               3'd0, topen_next, tcount_next);
                                n = n + 2'd1;
                            end
                            res[n[0]] = mk(KIND_DONE, '0, 3'd0, topen_next, tcount_next);
                            n = n + 2'd1;
                            mode_next   = M_LINE;
                            match_next  = 6'h3F;
                            klen_next   = '0;
                            tcount_next = '0;
                            topen_next  = 1'b0;
                            for (int i = 0; i < 4; i++)
                                field_next[i] = '0;
                            fcount_next = '0;
                            tlen_next   = '0;
                        end
                    end
                endcase
            end

            if (n != 2'd0)
                res[n[0] ^ 1'b1].last_result = 1'b1;
        end

        push.count = n;
        push.r0    = res[0];
        push.r1    = res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_LINE;
            match_reg  <= 6'h3F;
            klen_reg   <= '0;
            tcount_reg <= '0;
            topen_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
                field_reg[i] <= '0;
            quot_reg   <= '0;
            rem_reg    <= '0;
            fcount_reg <= '0;
            tlen_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            match_reg  <= match_next;
            klen_reg   <= klen_next;
            tcount_reg <= tcount_next;
            topen_reg  <= topen_next;
            for (int i = 0; i < 4; i++)
                field_reg[i] <= field_next[i];
            quot_reg   <= quot_next;
            rem_reg    <= rem_next;
            fcount_reg <= fcount_next;
            tlen_reg   <= tlen_next;
            halted_reg <= halted_next;
        end
    end

    // result queue
    cssp_out_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .count  (fifo_count),
        .out_ch (out_ch)
    );

    // queue never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= 3'd4)
        else $error("result queue overflow");

    // a halted parser produces nothing
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> push.count == 2'd0)
        else $error("results while halted");

    // an error as the first result of a byte halts the parser; an error is always its byte's last result
    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0 && push.r0.event_kind == KIND_ERROR) |=> halted_reg)
        else $error("error did not halt");

    // a byte with results marks exactly one last result; checked here for the two-result case
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (!push.r0.last_result && push.r1.last_result))
        else $error("last result mark misplaced");

endmodule

`default_nettype wire
